// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FMME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FMME_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FMME_ASSERT(label, prop, msg)
`define FMME_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- hw/rtl/fmme_pkg.sv -----
// Types, constants and the note table of the footswitch matrix event generator.
package fmme_pkg;

  localparam int BUTTONS_PER_ROW = 5;
  localparam int ROW_COUNT = 2;
  localparam int NUM_BUTTONS = ROW_COUNT * BUTTONS_PER_ROW;
  localparam int SENSE_W = 10;
  localparam int SENSE_PAIRS = (SENSE_W / 2 < BUTTONS_PER_ROW) ? SENSE_W / 2 : BUTTONS_PER_ROW;
  localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int COL_W = (BUTTONS_PER_ROW > 1) ? $clog2(BUTTONS_PER_ROW) : 1;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_STATUS_A = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STATUS_B = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VEL_LOW = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VEL_HIGH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BANK_BUTTON = 3'd4;

  localparam logic [7:0] RST_STATUS_A = 8'h96;
  localparam logic [7:0] RST_STATUS_B = 8'h97;
  localparam logic [6:0] RST_VEL_LOW = 7'h01;
  localparam logic [6:0] RST_VEL_HIGH = 7'h7F;
  localparam logic [3:0] RST_BANK_BUTTON = 4'd5;

  typedef enum logic [1:0] {
    PH_OPEN,
    PH_DOWN,
    PH_HELD,
    PH_UP
  } phase_t;

  typedef enum logic [1:0] {
    SEL_STATUS,
    SEL_NOTE,
    SEL_VEL
  } byte_sel_t;

  typedef struct packed {
    logic               scanned_row;
    logic [SENSE_W-1:0] sense_bits;
  } scan_t;

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       last_byte;
  } midi_t;

  typedef struct packed {
    logic [7:0] status_a;
    logic [7:0] status_b;
    logic [6:0] vel_low;
    logic [6:0] vel_high;
    logic [3:0] bank_button;
  } cfg_t;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] note;
    logic [6:0] vel;
  } msg_t;

  typedef struct packed {
    logic load;
    msg_t msg;
  } evt_t;

  function automatic logic [7:0] note_of(input logic [BTN_W-1:0] btn);
    logic [7:0] n;
    case (32'(btn))
      0: n = 8'd104;
      1: n = 8'd117;
      2: n = 8'd101;
      3: n = 8'd111;
      4: n = 8'd97;
      5: n = 8'd103;
      6: n = 8'd112;
      7: n = 8'd46;
      8: n = 8'd44;
      9: n = 8'd39;
      default: n = 8'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/fmme_cfg.sv -----
// Configuration register file with an APB-style access port.
module fmme_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fmme_pkg::ADDR_W-1:0] paddr,
  input  logic [fmme_pkg::DATA_W-1:0] pwdata,
  output logic [fmme_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output fmme_pkg::cfg_t              cfg
);
  import fmme_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.status_a <= RST_STATUS_A;
      cfg.status_b <= RST_STATUS_B;
      cfg.vel_low <= RST_VEL_LOW;
      cfg.vel_high <= RST_VEL_HIGH;
      cfg.bank_button <= RST_BANK_BUTTON;
    end else if (wr) begin
      case (idx)
        REG_STATUS_A: begin
          cfg.status_a <= pwdata[7:0];
        end
        REG_STATUS_B: begin
          cfg.status_b <= pwdata[7:0];
        end
        REG_VEL_LOW: begin
          cfg.vel_low <= pwdata[6:0];
        end
        REG_VEL_HIGH: begin
          cfg.vel_high <= pwdata[6:0];
        end
        REG_BANK_BUTTON: begin
          cfg.bank_button <= pwdata[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STATUS_A: prdata = DATA_W'(cfg.status_a);
      REG_STATUS_B: prdata = DATA_W'(cfg.status_b);
      REG_VEL_LOW: prdata = DATA_W'(cfg.vel_low);
      REG_VEL_HIGH: prdata = DATA_W'(cfg.vel_high);
      REG_BANK_BUTTON: prdata = DATA_W'(cfg.bank_button);
      default: prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/fmme_core.sv -----
// Input register, button phase machines, bank and velocity state, note event.
module fmme_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            scan_valid,
  output logic            scan_ready,
  input  fmme_pkg::scan_t scan,
  input  fmme_pkg::cfg_t  cfg,
  input  logic            load_ok,
  output fmme_pkg::evt_t  evt
);
  import fmme_pkg::*;

  logic                   s1_valid;
  scan_t                  s1;
  phase_t                 phase [NUM_BUTTONS];
  phase_t                 phase_next [NUM_BUTTONS];
  logic                   bank;
  logic [NUM_BUTTONS-1:0] vel_hi [2];

  logic                   found;
  logic [COL_W-1:0]       col;
  logic                   row_ok;
  logic                   down;
  logic [BTN_W-1:0]       ev_btn;
  logic                   is_bank;
  logic                   emit;
  logic                   s1_go;

  always_comb begin
    found = 1'b0;
    col = '0;
    for (int c = SENSE_PAIRS - 1; c >= 0; c--) begin
      if (s1.sense_bits[2*c +: 2] == 2'b00) begin
        found = 1'b1;
        col = COL_W'(c);
      end
    end
  end

  assign row_ok = int'(s1.scanned_row) < ROW_COUNT;

  always_comb begin
    down = 1'b0;
    ev_btn = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      phase_next[b] = phase[b];
      if (row_ok && int'(s1.scanned_row) == b / BUTTONS_PER_ROW) begin
        if (found && int'(col) == b % BUTTONS_PER_ROW) begin
          phase_next[b] = (phase[b] == PH_OPEN) ? PH_DOWN : PH_HELD;
          if (phase[b] == PH_OPEN) begin
            down = 1'b1;
            ev_btn = BTN_W'(b);
          end
        end else begin
          phase_next[b] = (phase[b] == PH_HELD) ? PH_UP : PH_OPEN;
        end
      end
    end
  end

  assign is_bank = 32'(ev_btn) == 32'(cfg.bank_button);
  assign emit = down & ~is_bank;
  assign s1_go = s1_valid & (~emit | load_ok);
  assign scan_ready = ~s1_valid | s1_go;

  assign evt.load = s1_go & emit;
  assign evt.msg.status = bank ? cfg.status_b : cfg.status_a;
  assign evt.msg.note = note_of(ev_btn);
  assign evt.msg.vel = vel_hi[bank][ev_btn] ? cfg.vel_high : cfg.vel_low;

  always_ff @(posedge clk) begin
    if (scan_valid && scan_ready) begin
      s1 <= scan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      phase <= '{default: PH_OPEN};
      bank <= 1'b0;
      vel_hi <= '{default: '0};
    end else begin
      if (scan_ready) begin
        s1_valid <= scan_valid;
      end
      if (s1_go) begin
        phase <= phase_next;
        if (down && is_bank) begin
          bank <= ~bank;
        end
        if (emit) begin
          vel_hi[bank][ev_btn] <= ~vel_hi[bank][ev_btn];
        end
      end
    end
  end

endmodule

// ----- hw/rtl/fmme_ser.sv -----
// Output register that sends a note message as three bytes.
module fmme_ser (
  input  logic            clk,
  input  logic            rst,
  input  fmme_pkg::evt_t  evt,
  output logic            load_ok,
  output logic            midi_valid,
  input  logic            midi_ready,
  output fmme_pkg::midi_t midi
);
  import fmme_pkg::*;

  logic      valid;
  byte_sel_t sel;
  msg_t      msg;

  assign midi_valid = valid;
  assign load_ok = ~valid | (midi_ready & (sel == SEL_VEL));

  always_ff @(posedge clk) begin
    if (evt.load) begin
      msg <= evt.msg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sel <= SEL_STATUS;
    end else if (evt.load) begin
      valid <= 1'b1;
      sel <= SEL_STATUS;
    end else if (valid && midi_ready) begin
      case (sel)
        SEL_STATUS: begin
          sel <= SEL_NOTE;
        end
        SEL_NOTE: begin
          sel <= SEL_VEL;
        end
        default: begin
          valid <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    case (sel)
      SEL_STATUS: begin
        midi.midi_byte = msg.status;
        midi.last_byte = 1'b0;
      end
      SEL_NOTE: begin
        midi.midi_byte = msg.note;
        midi.last_byte = 1'b0;
      end
      SEL_VEL: begin
        midi.midi_byte = {1'b0, msg.vel};
        midi.last_byte = 1'b1;
      end
      default: begin
        midi.midi_byte = '0;
        midi.last_byte = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/footswitch_matrix_midi_events_top.sv -----
// Top level of the footswitch matrix scanner that emits MIDI note bytes.
// A scan item (driven row plus ten sense bits) is taken into an input register and
// evaluated there; a scan that causes no note frees the register at once, so such
// scans are accepted every cycle. A scan that presses a note button loads a
// three-byte message into the output register, which presents status, note and
// velocity bytes in that order, each held until taken, last_byte marking the
// velocity. The output register sets the rate: a note-producing scan waits in the
// input register until the output register is free, and the next message loads in
// the same cycle the previous velocity byte is taken. State resets synchronously;
// registers at byte address 4*i, read back with unused upper bits as zero.
module footswitch_matrix_midi_events_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fmme_pkg::ADDR_W-1:0] paddr,
  input  logic [fmme_pkg::DATA_W-1:0] pwdata,
  output logic [fmme_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        scan_valid,
  output logic                        scan_ready,
  input  fmme_pkg::scan_t             scan,
  output logic                        midi_valid,
  input  logic                        midi_ready,
  output fmme_pkg::midi_t             midi
);
  import fmme_pkg::*;
`include "assert_macros.svh"

  cfg_t cfg;
  evt_t evt;
  logic load_ok;

  fmme_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fmme_core u_core (
    .clk        (clk),
    .rst        (rst),
    .scan_valid (scan_valid),
    .scan_ready (scan_ready),
    .scan       (scan),
    .cfg        (cfg),
    .load_ok    (load_ok),
    .evt        (evt)
  );

  fmme_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .load_ok    (load_ok),
    .midi_valid (midi_valid),
    .midi_ready (midi_ready),
    .midi       (midi)
  );

  `FMME_ASSERT_ALWAYS(a_idle_after_rst, rst |=> !midi_valid, "output valid after reset")
  `FMME_ASSERT(a_no_overwrite,
               evt.load |-> (!midi_valid || (midi_ready && midi.last_byte)),
               "message loaded over pending bytes")
  `FMME_ASSERT(a_msg_continues, (midi_valid && midi_ready && !midi.last_byte) |=> midi_valid,
               "message cut short")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the footswitch matrix MIDI note byte generator.

class note_message_tracker;
  fmme_pkg::phase_t phase[fmme_pkg::NUM_BUTTONS];
  bit               bank_b;
  bit               vel_high_sel[2][fmme_pkg::NUM_BUTTONS];
  logic [7:0]       status_a;
  logic [7:0]       status_b;
  logic [6:0]       vel_lo;
  logic [6:0]       vel_hi;
  logic [3:0]       bank_btn;
  byte unsigned     note_table[10] = '{104, 117, 101, 111, 97, 103, 112, 46, 44, 39};
  fmme_pkg::midi_t  pending_bytes[$];
  int               mismatches;

  function new();
    foreach (phase[i]) phase[i] = fmme_pkg::PH_OPEN;
    foreach (vel_high_sel[k, i]) vel_high_sel[k][i] = 1'b0;
    bank_b = 1'b0;
    status_a = 8'h96;
    status_b = 8'h97;
    vel_lo = 7'h01;
    vel_hi = 7'h7F;
    bank_btn = 4'd5;
    mismatches = 0;
  endfunction

  function void set_register(logic [fmme_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      fmme_pkg::REG_STATUS_A: status_a = val[7:0];
      fmme_pkg::REG_STATUS_B: status_b = val[7:0];
      fmme_pkg::REG_VEL_LOW: vel_lo = val[6:0];
      fmme_pkg::REG_VEL_HIGH: vel_hi = val[6:0];
      fmme_pkg::REG_BANK_BUTTON: bank_btn = val[3:0];
      default: ;
    endcase
  endfunction

  function void note_scan(fmme_pkg::scan_t s);
    int               col;
    int               b;
    bit               hit;
    bit               sent;
    fmme_pkg::phase_t ph;
    fmme_pkg::midi_t  m;
    if (int'(s.scanned_row) >= fmme_pkg::ROW_COUNT) return;
    hit = 1'b0;
    sent = 1'b0;
    col = 0;
    for (int c = 0; c < fmme_pkg::SENSE_PAIRS; c++) begin
      if (!hit && s.sense_bits[2*c +: 2] == 2'b00) begin
        hit = 1'b1;
        col = c;
      end
    end
    for (int c = 0; c < fmme_pkg::BUTTONS_PER_ROW; c++) begin
      b = int'(s.scanned_row) * fmme_pkg::BUTTONS_PER_ROW + c;
      ph = phase[b];
      if (hit && c == col) ph = (ph == fmme_pkg::PH_OPEN) ? fmme_pkg::PH_DOWN : fmme_pkg::PH_HELD;
      else ph = (ph == fmme_pkg::PH_HELD) ? fmme_pkg::PH_UP : fmme_pkg::PH_OPEN;
      phase[b] = ph;
      if (ph == fmme_pkg::PH_DOWN) begin
        if (b == int'(bank_btn)) begin
          bank_b = ~bank_b;
        end else if (!sent) begin
          m.midi_byte = bank_b ? status_b : status_a;
          m.last_byte = 1'b0;
          pending_bytes.push_back(m);
          m.midi_byte = (b < 10) ? note_table[b] : 8'd0;
          pending_bytes.push_back(m);
          m.midi_byte = {1'b0, vel_high_sel[bank_b][b] ? vel_hi : vel_lo};
          m.last_byte = 1'b1;
          pending_bytes.push_back(m);
          vel_high_sel[bank_b][b] = ~vel_high_sel[bank_b][b];
          sent = 1'b1;
        end
      end
    end
  endfunction

  task report(string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  task check_byte(fmme_pkg::midi_t got);
    fmme_pkg::midi_t want;
    if (pending_bytes.size() == 0) begin
      report($sformatf("unexpected byte %02h last %0b", got.midi_byte, got.last_byte));
    end else begin
      want = pending_bytes.pop_front();
      if (got.midi_byte !== want.midi_byte)
        report($sformatf("midi_byte %02h, want %02h", got.midi_byte, want.midi_byte));
      if (got.last_byte !== want.last_byte)
        report($sformatf("last_byte %0b, want %0b", got.last_byte, want.last_byte));
    end
  endtask
endclass

module testbench;
  import fmme_pkg::*;

  localparam int NO_PRESS = BUTTONS_PER_ROW;
  localparam int ITEMS_PER_PHASE = 42;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                scan_valid;
  logic                scan_ready;
  scan_t               scan;
  logic                midi_valid;
  logic                midi_ready;
  midi_t               midi;

  note_message_tracker tracker = new();
  int                  send_idle_pct;
  int                  recv_idle_pct;
  bit                  stall_pending;

  footswitch_matrix_midi_events_top DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .scan_valid(scan_valid), .scan_ready(scan_ready), .scan(scan),
    .midi_valid(midi_valid), .midi_ready(midi_ready), .midi(midi)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("footswitch_matrix_midi_events_top verification failed");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    midi_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && midi_valid && midi_ready) tracker.check_byte(midi);
      if (stall_pending) begin
        stall_left = 150;
        stall_pending = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        midi_ready <= 1'b0;
      end else begin
        midi_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [SENSE_W-1:0] sense_for(int col);
    logic [SENSE_W-1:0] s;
    for (int c = 0; c < SENSE_W / 2; c++) begin
      if (c < col) s[2*c +: 2] = 2'($urandom_range(3, 1));
      else if (c == col) s[2*c +: 2] = 2'b00;
      else s[2*c +: 2] = 2'($urandom_range(3));
    end
    return s;
  endfunction

  function automatic scan_t random_scan();
    scan_t s;
    int    r;
    r = $urandom_range(99);
    s.scanned_row = 1'($urandom_range(1));
    if (r < 8) s.sense_bits = SENSE_W'($urandom);
    else if (r < 60) s.sense_bits = sense_for($urandom_range(BUTTONS_PER_ROW - 1));
    else s.sense_bits = sense_for(NO_PRESS);
    return s;
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct = 9;
        recv_idle_pct = 84;
      end
      1: begin
        send_idle_pct = 84;
        recv_idle_pct = 9;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send_scan(scan_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      scan_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan <= s;
    scan_valid <= 1'b1;
    do @(posedge clk); while (!scan_ready);
    tracker.note_scan(s);
  endtask

  task automatic press(logic row, int col);
    scan_t s;
    s.scanned_row = row;
    s.sense_bits = sense_for(col);
    send_scan(s);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    scan_valid <= 1'b0;
    while (tracker.pending_bytes.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [7:0] st_a, logic [7:0] st_b, logic [6:0] lo,
                                logic [6:0] hi, logic [3:0] bank);
    apb_write(REG_STATUS_A, 32'(st_a));
    apb_write(REG_STATUS_B, 32'(st_b));
    apb_write(REG_VEL_LOW, 32'(lo));
    apb_write(REG_VEL_HIGH, 32'(hi));
    apb_write(REG_BANK_BUTTON, 32'(bank));
  endtask

  initial begin
    scan_t      s;
    logic [6:0] vel;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    scan_valid <= 1'b0;
    scan <= '0;
    stall_pending = 1'b0;
    set_idling(2);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    s.scanned_row = 1'b0;
    s.sense_bits = '0;
    send_scan(s);
    s.sense_bits = '1;
    send_scan(s);
    press(1'b0, 0);
    press(1'b0, 0);
    press(1'b0, 1);
    press(1'b0, NO_PRESS);
    press(1'b0, 2);
    press(1'b0, 3);
    press(1'b0, 4);
    press(1'b1, 0);
    press(1'b1, NO_PRESS);
    press(1'b0, NO_PRESS);
    press(1'b0, 0);
    for (int c = 1; c < BUTTONS_PER_ROW; c++) press(1'b1, c);
    press(1'b1, 0);
    press(1'b1, NO_PRESS);
    s.scanned_row = 1'b1;
    s.sense_bits = 10'b00_11_00_01_10;
    send_scan(s);
    press(1'b0, NO_PRESS);
    press(1'b0, 4);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_settings(8'h00, 8'hFF, 7'h00, 7'h7F, 4'd0);
        1: apply_settings(8'hFF, 8'h00, 7'h7F, 7'h00, 4'd9);
        2: begin
          vel = 7'($urandom);
          apply_settings(8'($urandom), 8'($urandom), vel, vel, 4'd15);
        end
        3: apply_settings(8'($urandom), 8'($urandom), 7'($urandom), 7'($urandom),
                          4'($urandom_range(15)));
        4: apply_settings(8'($urandom), 8'($urandom), 7'($urandom), 7'($urandom),
                          4'($urandom_range(9)));
        default: apply_settings(8'($urandom), 8'($urandom), 7'($urandom), 7'($urandom),
                                4'd5);
      endcase
      set_idling(p % 3);
      if (p % 3 == 2) stall_pending = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_scan(random_scan());
      drain();
    end

    if (tracker.pending_bytes.size() != 0)
      tracker.report($sformatf("%0d bytes never arrived", tracker.pending_bytes.size()));
    if (tracker.mismatches == 0) begin
      $display("footswitch_matrix_midi_events_top verification clean");
    end else begin
      $display("footswitch_matrix_midi_events_top verification failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/fmme_pkg.sv
hw/rtl/fmme_cfg.sv
hw/rtl/fmme_core.sv
hw/rtl/fmme_ser.sv
hw/rtl/footswitch_matrix_midi_events_top.sv
dv/testbench.sv
